>>> hw/rtl/crcdf_pkg.sv
// Package: types, constants and the CRC-16 byte update for the response deframer.
`default_nettype none

package crcdf_pkg;

	localparam logic [15:0] CrcPoly  = 16'h8005;
	localparam logic [7:0]  MinFrame = 8'd4;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		VERDICT_OK         = 2'd0,
		VERDICT_COUNT_BAD  = 2'd1,
		VERDICT_CRC_BAD    = 2'd2,
		VERDICT_STATUS_BAD = 2'd3
	} verdict_t;

	typedef enum logic [7:0] {
		REG_FRAME_LENGTH = 8'd0,
		REG_STATUS_MODE  = 8'd1
	} reg_index_t;

	// one byte into the CRC, data bits least significant first
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			if (b[i] != c[15]) begin
				c = {c[14:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/crc_checked_response_deframer.sv
// Top level: length-prefixed response frame checker with CRC-16 (0x8005).
`default_nettype none

// Takes one response byte per cycle while the output is not stalled. An
// accepted byte lands in an input register; once the output can advance, the
// frame position, CRC-16 update and verdict logic act on it and load the
// result register. The count byte and the CRC low byte give no result. Each
// payload byte comes out with its index; the CRC high byte gives the verdict
// (count mismatch, then CRC mismatch, then in status mode a non-zero first
// payload byte). Drop the frame's payload when the verdict is not ok. Write
// configuration only while no byte is in flight.
module crc_checked_response_deframer #(
	parameter int MAX_FRAME = 255
) (
	input  wire logic       clk,
	input  wire logic       arst_n,

	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_index,
	input  wire logic [7:0] cfg_data,

	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,

	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            kind,
	output logic [7:0]      payload_byte,
	output logic [7:0]      payload_index,
	output logic [1:0]      verdict,
	output logic [7:0]      status_value,
	output logic            last
);

	localparam logic [7:0] MaxLen = 8'(MAX_FRAME);

	logic [7:0]  frame_length_q;
	logic        status_mode_q;

	logic        in_valid_s1;
	logic [7:0]  rx_byte_s1;

	logic [15:0] crc_q;
	logic [7:0]  pos_q;
	logic        count_bad_q;
	logic [7:0]  crc_low_q;
	logic [7:0]  first_payload_q;

	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  payload_byte_q;
	logic [7:0]  payload_index_q;
	logic [1:0]  verdict_q;
	logic [7:0]  status_value_q;
	logic        last_q;

	logic        advance;
	logic        take;
	logic [7:0]  eff_len;
	logic        is_count;
	logic        is_close;
	logic        is_crc_low;
	logic        is_payload;
	logic [15:0] crc_next;
	logic [15:0] crc_recv;
	crcdf_pkg::verdict_t verdict_next;

	assign cfg_ready = 1'b1;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = in_valid_s1 && !advance;
	assign take     = in_valid_s1 && advance;

	always_comb begin
		if (frame_length_q < crcdf_pkg::MinFrame) begin
			eff_len = crcdf_pkg::MinFrame;
		end else if (frame_length_q > MaxLen) begin
			eff_len = MaxLen;
		end else begin
			eff_len = frame_length_q;
		end
	end

	assign is_count   = (pos_q == 8'd0);
	assign is_close   = !is_count && (pos_q >= eff_len - 8'd1);
	assign is_crc_low = !is_count && !is_close && (pos_q == eff_len - 8'd2);
	assign is_payload = !is_count && !is_close && !is_crc_low;

	assign crc_next = crcdf_pkg::crc_feed(crc_q, rx_byte_s1);
	assign crc_recv = {rx_byte_s1, crc_low_q};

	always_comb begin
		priority if (count_bad_q) begin
			verdict_next = crcdf_pkg::VERDICT_COUNT_BAD;
		end else if (crc_recv != crc_q) begin
			verdict_next = crcdf_pkg::VERDICT_CRC_BAD;
		end else if (status_mode_q && (first_payload_q != 8'd0)) begin
			verdict_next = crcdf_pkg::VERDICT_STATUS_BAD;
		end else begin
			verdict_next = crcdf_pkg::VERDICT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q <= 8'd4;
			status_mode_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == crcdf_pkg::REG_FRAME_LENGTH) begin
				frame_length_q <= cfg_data;
			end else if (cfg_index == crcdf_pkg::REG_STATUS_MODE) begin
				status_mode_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q           <= '0;
			pos_q           <= '0;
			count_bad_q     <= 1'b0;
			crc_low_q       <= '0;
			first_payload_q <= '0;
		end else if (take) begin
			if (is_count) begin
				count_bad_q <= (rx_byte_s1 != eff_len);
				crc_q       <= crc_next;
				pos_q       <= 8'd1;
			end else if (is_close) begin
				crc_q           <= '0;
				pos_q           <= '0;
				count_bad_q     <= 1'b0;
				crc_low_q       <= '0;
				first_payload_q <= '0;
			end else if (is_crc_low) begin
				crc_low_q <= rx_byte_s1;
				pos_q     <= pos_q + 8'd1;
			end else begin
				if (pos_q == 8'd1) begin
					first_payload_q <= rx_byte_s1;
				end
				crc_q <= crc_next;
				pos_q <= pos_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= take && (is_close || is_payload);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (is_close) begin
				kind_q          <= crcdf_pkg::KIND_VERDICT;
				payload_byte_q  <= '0;
				payload_index_q <= '0;
				verdict_q       <= verdict_next;
				status_value_q  <= first_payload_q;
				last_q          <= 1'b1;
			end else begin
				kind_q          <= crcdf_pkg::KIND_PAYLOAD;
				payload_byte_q  <= rx_byte_s1;
				payload_index_q <= pos_q - 8'd1;
				verdict_q       <= crcdf_pkg::VERDICT_OK;
				status_value_q  <= '0;
				last_q          <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign payload_byte  = payload_byte_q;
	assign payload_index = payload_index_q;
	assign verdict       = verdict_q;
	assign status_value  = status_value_q;
	assign last          = last_q;

`ifndef SYNTH
	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> in_valid_s1)
		else $error("input stalled with empty input register");

	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < MaxLen)
		else $error("frame position beyond maximum frame");

	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && is_close |=> pos_q == 8'd0 && crc_q == 16'd0 && !count_bad_q)
		else $error("frame state not cleared after verdict");

	a_last_is_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (last_q == kind_q))
		else $error("last and kind disagree");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q == crcdf_pkg::KIND_PAYLOAD)
			|-> verdict_q == crcdf_pkg::VERDICT_OK && status_value_q == 8'd0)
		else $error("payload result carries verdict fields");
`endif

endmodule

`default_nettype wire
